[hw/rtl/kbdc_pkg.sv]
// ============================================================================
// kbdc_pkg - shared types and constants of the keystream byte descrambler
// Holds the command format that travels from the front end through the queue
// to the back end, the checksum and keystream constants, and helpers.
// ============================================================================
package kbdc_pkg;

    // Input action codes.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    // Checksum and keystream constants.
    localparam logic [15:0] SUM_SEED   = 16'hA2F1;
    localparam logic [15:0] EXPECT_XOR = 16'hEB7D;

    // Default depth of the command queue between front and back end.
    localparam int KBDC_QUEUE_DEPTH = 2;

    // One classified command. For a start it carries the expected checksum,
    // for a data item the scrambled byte in the low eight bits.
    typedef struct packed {
        logic        is_start;
        logic        is_last;
        logic [15:0] word;
    } t_cmd;

    // Queue status seen by the front end and the top level.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [15:0] ror16_by3(input logic [15:0] v);
        return {v[2:0], v[15:3]};
    endfunction

    function automatic logic [15:0] ror16_by1(input logic [15:0] v);
        return {v[0], v[15:1]};
    endfunction

endpackage

[hw/rtl/kbdc_front.sv]
// ============================================================================
// kbdc_front - input front end
// Accepts input items, classifies them and turns a start item's trailer word
// into the expected checksum before the command enters the queue.
// ============================================================================
module kbdc_front
    import kbdc_pkg::*;
(
    input  logic        i_valid,
    input  logic        i_action,
    input  logic [15:0] i_trailer_word,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    input  t_q_status   i_q_status,
    output logic        o_stall,
    output logic        o_push,
    output t_cmd        o_cmd
);

    // The queue is the only thing that can hold the input back.
    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    always_comb begin
        o_cmd.is_last = i_is_last;
        if (i_action == ACT_START) begin
            o_cmd.is_start = 1'b1;
            o_cmd.word     = ror16_by3(i_trailer_word) ^ EXPECT_XOR;
        end else begin
            o_cmd.is_start = 1'b0;
            o_cmd.word     = {8'h00, i_data_byte};
        end
    end

endmodule

[hw/rtl/kbdc_queue.sv]
// ============================================================================
// kbdc_queue - command queue
// A small first-in first-out queue of classified commands that decouples the
// front end from the back end.
// ============================================================================
module kbdc_queue
    import kbdc_pkg::*;
#(
    parameter int QUEUE_DEPTH = KBDC_QUEUE_DEPTH
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_cmd             r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_cmd           = r_entry[r_rd_ptr];
    assign o_status.full   = (r_count == FULL_CNT);
    assign o_status.empty  = (r_count == '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[hw/rtl/kbdc_back.sv]
// ============================================================================
// kbdc_back - descrambler back end
// Executes queued commands: keeps the keystream state and both checksums,
// decodes data bytes and holds each result in the output register.
// ============================================================================
module kbdc_back
    import kbdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_q_status   i_q_status,
    input  logic        i_stall,
    output logic        o_pop,
    output logic        o_valid,
    output logic [7:0]  o_plain_byte,
    output logic        o_byte_valid,
    output logic        o_region_done,
    output logic        o_checksum_ok
);

    logic [15:0] r_key,  n_key;
    logic [15:0] r_sum,  n_sum;
    logic [15:0] r_exp,  n_exp;
    logic        r_valid, n_valid;
    logic [7:0]  r_plain, n_plain;
    logic        r_bv, n_bv;
    logic        r_done, n_done;
    logic        r_ok, n_ok;

    logic        out_free;
    logic [7:0]  plain;
    logic [15:0] key_rot;

    // A command executes when the output register is empty or being taken.
    assign out_free = !r_valid || !i_stall;
    assign o_pop    = out_free && !i_q_status.empty;

    assign plain   = i_cmd.word[7:0] ^ r_key[7:0];
    assign key_rot = ror16_by1(r_key);

    always_comb begin
        n_key   = r_key;
        n_sum   = r_sum;
        n_exp   = r_exp;
        n_valid = r_valid && i_stall;
        n_plain = r_plain;
        n_bv    = r_bv;
        n_done  = r_done;
        n_ok    = r_ok;
        if (o_pop) begin
            if (i_cmd.is_start) begin
                n_exp = i_cmd.word;
                n_key = i_cmd.word;
                n_sum = SUM_SEED;
                if (i_cmd.is_last) begin
                    n_valid = 1'b1;
                    n_plain = 8'h00;
                    n_bv    = 1'b0;
                    n_done  = 1'b1;
                    n_ok    = (SUM_SEED == i_cmd.word);
                end
            end else begin
                // Seven times the byte is eight times less one time.
                n_sum   = r_sum + {5'b0, plain, 3'b000} - {8'h00, plain};
                n_key   = {key_rot[13:0], 2'b00} + key_rot + 16'd1;
                n_valid = 1'b1;
                n_plain = plain;
                n_bv    = 1'b1;
                n_done  = i_cmd.is_last;
                n_ok    = i_cmd.is_last && (n_sum == r_exp);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_sum   <= SUM_SEED;
            r_exp   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_key   <= n_key;
            r_sum   <= n_sum;
            r_exp   <= n_exp;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plain <= n_plain;
        r_bv    <= n_bv;
        r_done  <= n_done;
        r_ok    <= n_ok;
    end

    assign o_valid       = r_valid;
    assign o_plain_byte  = r_plain;
    assign o_byte_valid  = r_bv;
    assign o_region_done = r_done;
    assign o_checksum_ok = r_ok;

endmodule

[hw/rtl/keystream_byte_descrambler_checksum.sv]
// ============================================================================
// keystream_byte_descrambler_checksum - keystream descrambler with checksum
// Descrambles a region byte by byte and checks it against the trailer word.
// ============================================================================
// Flow: an item is written into the queue, then the back end executes it into the
// output register when that register is empty or being taken; a stall holds it.
// Throughput: one item per cycle unless stalled; the back end's state update
// (rotate, multiply by five, add one, checksum add) is combinational.
// Reset (synchronous, active low): the queue and output register are emptied,
// the keystream state and expected checksum go to zero and the running
// checksum to its seed value.
// ============================================================================
module keystream_byte_descrambler_checksum
    import kbdc_pkg::*;
#(
    parameter int QUEUE_DEPTH = KBDC_QUEUE_DEPTH
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [15:0] i_trailer_word,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    // Result channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_plain_byte,
    output logic        o_byte_valid,
    output logic        o_region_done,
    output logic        o_checksum_ok
);

    // The front end classifies each item and precomputes the expected
    // checksum of a start item, so that the back end only has to load it.
    t_cmd      front_cmd;
    t_cmd      queue_cmd;
    t_q_status q_status;
    logic      push;
    logic      pop;

    kbdc_front u_front (
        .i_valid        (i_valid),
        .i_action       (i_action),
        .i_trailer_word (i_trailer_word),
        .i_data_byte    (i_data_byte),
        .i_is_last      (i_is_last),
        .i_q_status     (q_status),
        .o_stall        (o_stall),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    // The queue lets the input side keep accepting items while a finished
    // result waits at the output; the stall seen upstream comes only from
    // the queue being full, never directly from the downstream stall.
    kbdc_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (queue_cmd),
        .o_status (q_status)
    );

    // The back end owns all region state. A start item that does not end an
    // empty region updates the state and leaves no result.
    kbdc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (queue_cmd),
        .i_q_status    (q_status),
        .i_stall       (i_stall),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_plain_byte  (o_plain_byte),
        .o_byte_valid  (o_byte_valid),
        .o_region_done (o_region_done),
        .o_checksum_ok (o_checksum_ok)
    );

    // An accepted item is in the queue at the next edge, popped or not.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> !q_status.empty)
        else $error("accepted item did not reach the command queue");

    // A result without a decoded byte can only be the end of an empty region.
    a_empty_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_valid) |-> (o_region_done && (o_plain_byte == 8'h00)))
        else $error("result without a byte is not an empty region end");

    // A passing checksum is only ever reported at the end of a region.
    a_ok_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_checksum_ok) |-> o_region_done)
        else $error("checksum reported outside a region end");

endmodule

[sim/keystream_byte_descrambler_checksum_test.sv]
// ============================================================================
// keystream_byte_descrambler_checksum_test - descrambler regression bench
// Drives start and data items into the descrambler, predicts every decoded
// byte and region verdict with an independent model of the keystream and the
// checksum, and compares each result item in order. A short directed table
// opens the run, then random regions and noise follow under three idling
// patterns on the input and result channels.
// ============================================================================
module keystream_byte_descrambler_checksum_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kbdc_pkg::*;

    // The bench keeps its own copy of the checksum and keystream constants so
    // that a wrong value in the package cannot hide itself.
    localparam logic [15:0] CSUM_START  = 16'hA2F1;
    localparam logic [15:0] TRAILER_XOR = 16'hEB7D;
    localparam logic [15:0] CSUM_WEIGHT = 16'd7;
    localparam logic [15:0] KS_MULT     = 16'd5;
    localparam logic [15:0] KS_INC      = 16'd1;

    localparam int ITEMS_PER_PHASE = 430;
    localparam int MAX_REPORTS     = 10;
    localparam int DRAIN_CYCLES    = 8;

    // One input item as it goes across the input channel.
    typedef struct packed {
        logic        action;
        logic [15:0] trailer;
        logic [7:0]  data;
        logic        last;
    } t_scr_item;

    // One result item as it comes back on the result channel.
    typedef struct packed {
        logic [7:0] plain;
        logic       byte_valid;
        logic       region_done;
        logic       checksum_ok;
    } t_plain_result;

    // A row of the directed table. When typed is set, want is the result read
    // straight off the specification; otherwise the predictor supplies it.
    typedef struct packed {
        t_scr_item     item;
        logic          typed;
        t_plain_result want;
    } t_directed_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_stall;
    logic        i_action       = ACT_START;
    logic [15:0] i_trailer_word = 16'h0000;
    logic [7:0]  i_data_byte    = 8'h00;
    logic        i_is_last      = 1'b0;
    logic        o_valid;
    logic        i_stall        = 1'b0;
    logic [7:0]  o_plain_byte;
    logic        o_byte_valid;
    logic        o_region_done;
    logic        o_checksum_ok;

    // Predictor state: keystream, running checksum and the checksum that the
    // trailer word of the current region promises.
    logic [15:0] ks_state     = 16'h0000;
    logic [15:0] csum_running = CSUM_START;
    logic [15:0] csum_target  = 16'h0000;

    // Results that have been predicted for accepted items and not yet seen.
    t_plain_result decoded_awaited[$];

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int sent_items     = 0;
    int mismatch_count = 0;

    // The directed part. It starts with data before any start item, so the
    // keystream is still zero and the first decoded byte equals its input byte.
    // Trailer 0x4C62 gives an expected checksum equal to the seed 0xA2F1, so
    // the empty region it opens passes. The same trailer then opens a region
    // whose three bytes all decode to zero, which must also pass. After that
    // come data after a region has ended, a restart in mid region, and the
    // bit extremes of every field.
    t_directed_row directed_rows [18] = '{
        '{'{ACT_DATA,  16'h0000, 8'hFF, 1'b0}, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
        '{'{ACT_DATA,  16'hFFFF, 8'h00, 1'b1}, 1'b1, '{8'h01, 1'b1, 1'b1, 1'b0}},
        '{'{ACT_START, 16'h0000, 8'h00, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
        '{'{ACT_START, 16'hFFFF, 8'hFF, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
        '{'{ACT_START, 16'h4C62, 8'h00, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
        '{'{ACT_START, 16'h4C62, 8'hFF, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_DATA,  16'h0000, 8'hF1, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
        '{'{ACT_DATA,  16'hFFFF, 8'h59, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
        '{'{ACT_DATA,  16'h0000, 8'h5D, 1'b1}, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}},
        '{'{ACT_DATA,  16'h0000, 8'hA5, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_DATA,  16'hFFFF, 8'h5A, 1'b1}, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_START, 16'hFFFF, 8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_DATA,  16'h0000, 8'hFF, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_START, 16'h1234, 8'hFF, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_DATA,  16'hFFFF, 8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_DATA,  16'h0000, 8'h80, 1'b1}, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_START, 16'h8001, 8'h00, 1'b0}, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}},
        '{'{ACT_DATA,  16'h0000, 8'h7F, 1'b1}, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0}}
    };

    keystream_byte_descrambler_checksum dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_trailer_word (i_trailer_word),
        .i_data_byte    (i_data_byte),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_plain_byte   (o_plain_byte),
        .o_byte_valid   (o_byte_valid),
        .o_region_done  (o_region_done),
        .o_checksum_ok  (o_checksum_ok)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // One keystream step: rotate right by one, times five, plus one, all
    // modulo 2^16. The stimulus side uses it too, to scramble bytes.
    function automatic logic [15:0] advance_key(input logic [15:0] key);
        logic [15:0] rotated;
        rotated = {key[0], key[15:1]};
        return rotated * KS_MULT + KS_INC;
    endfunction

    // Applies one accepted item to the predictor state. Returns 1 when the
    // item causes a result, which is then placed in res.
    function automatic bit descramble_step(input t_scr_item it,
                                           output t_plain_result res);
        logic [7:0] plain;
        res = '0;
        if (it.action == ACT_START) begin
            // The trailer word rotated right by three, then XORed, is both
            // the promised checksum and the keystream seed.
            csum_target     = {it.trailer[2:0], it.trailer[15:3]} ^ TRAILER_XOR;
            ks_state        = csum_target;
            csum_running    = CSUM_START;
            res.region_done = 1'b1;
            res.checksum_ok = (csum_running == csum_target);
            // Only an empty region reports anything at its start.
            return it.last;
        end
        plain           = it.data ^ ks_state[7:0];
        csum_running    = csum_running + CSUM_WEIGHT * {8'h00, plain};
        ks_state        = advance_key(ks_state);
        res.plain       = plain;
        res.byte_valid  = 1'b1;
        res.region_done = it.last;
        res.checksum_ok = it.last && (csum_running == csum_target);
        return 1'b1;
    endfunction

    // Offers one item after a random gap, holds it until it is taken, and
    // records what it should produce. Returns in the time step of the
    // accepting edge without touching i_valid, so a following item keeps
    // valid high without a glitch.
    task automatic send_item(input t_scr_item it, input logic typed = 1'b0,
                             input t_plain_result want = '0);
        t_plain_result predicted;
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= it.action;
        i_trailer_word <= it.trailer;
        i_data_byte    <= it.data;
        i_is_last      <= it.last;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        sent_items++;
        if (descramble_step(it, predicted)) begin
            decoded_awaited.push_back(typed ? want : predicted);
        end
    endtask

    // Stops sending and waits until every predicted result has come back.
    // The extra edge keeps the lowering of valid apart from the next raise.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (decoded_awaited.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Sends one well-formed region: a start item and its data bytes. Half of
    // the regions carry a trailer word that matches the plaintext checksum,
    // so the pass verdict is reached as often as the fail verdict. About one
    // region in eight is empty, and a few are long.
    task automatic send_region();
        logic [7:0]  plain_q[$];
        logic [15:0] sum;
        logic [15:0] target;
        logic [15:0] key;
        int          n;
        t_scr_item   it;
        if ($urandom_range(7) == 0) begin
            n = 0;
        end else if ($urandom_range(9) == 0) begin
            n = $urandom_range(40, 9);
        end else begin
            n = $urandom_range(8, 1);
        end
        // The running checksum depends on the plaintext only, so it can be
        // worked out before the keystream is known.
        sum = CSUM_START;
        for (int k = 0; k < n; k++) begin
            plain_q.push_back(8'($urandom));
            sum = sum + CSUM_WEIGHT * {8'h00, plain_q[k]};
        end
        target     = $urandom_range(1) ? sum : 16'($urandom);
        key        = target ^ TRAILER_XOR;
        it.action  = ACT_START;
        it.trailer = {key[12:0], key[15:13]};
        it.data    = 8'($urandom);
        it.last    = (n == 0);
        send_item(it);
        // Scramble the plaintext with the keystream that the target seeds.
        key = target;
        for (int k = 0; k < n; k++) begin
            it.action  = ACT_DATA;
            it.trailer = 16'($urandom);
            it.data    = plain_q[k] ^ key[7:0];
            it.last    = (k == n - 1);
            send_item(it);
            key = advance_key(key);
        end
    endtask

    // The receiver stalls at random with the rate of the current phase.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Every result item taken on the result channel is compared with the
    // oldest prediction. A result with nothing waiting is a failure too.
    always @(posedge i_clk) begin : result_monitor
        t_plain_result got;
        t_plain_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_plain_byte, o_byte_valid, o_region_done, o_checksum_ok};
            if (decoded_awaited.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected result plain %02h valid %b done %b ok %b",
                             $time, got.plain, got.byte_valid, got.region_done,
                             got.checksum_ok);
                end
            end else begin
                want = decoded_awaited.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: expected %02h %b %b %b, got %02h %b %b %b",
                                 $time, want.plain, want.byte_valid, want.region_done,
                                 want.checksum_ok, got.plain, got.byte_valid,
                                 got.region_done, got.checksum_ok);
                    end
                end
            end
        end
    end

    // Main sequence: reset, the directed table, then three random phases.
    // The first phase has a busy sender against a mostly stalled receiver,
    // the second the opposite, and the third runs at full rate on both sides.
    initial begin : stimulus
        t_scr_item noise;
        send_gap_pct   = 19;
        recv_stall_pct = 88;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].item, directed_rows[r].typed,
                      directed_rows[r].want);
        end
        // Let the block run completely dry once before the random part.
        wait_for_drain();

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_gap_pct   = 88;
                recv_stall_pct = 19;
            end else if (phase == 2) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            while (sent_items < $size(directed_rows) + (phase + 1) * ITEMS_PER_PHASE) begin
                if ($urandom_range(3) != 0) begin
                    send_region();
                end else begin
                    // Noise: any item at all, which also breaks regions up
                    // with stray data and restarts.
                    noise.action  = 1'($urandom_range(1));
                    noise.trailer = 16'($urandom);
                    noise.data    = 8'($urandom);
                    noise.last    = ($urandom_range(3) == 0);
                    send_item(noise);
                end
            end
            wait_for_drain();
        end

        // Any late extra result shows up as an unexpected one here.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && decoded_awaited.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Hang guard, far above the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
